@@ rtl/ddo_pkg.sv @@
// Shared constants, types and the arctangent table of the odometry block.
package ddo_pkg;

    localparam int ANGLE_BITS      = 20;
    localparam int TRIG_ITERATIONS = 18;
    localparam int ITER_W          = $clog2(TRIG_ITERATIONS);
    localparam int ATAN_IDX_W      = 5;

    localparam int SPEED_W       = 13;
    localparam int SUM_W         = SPEED_W + 1;
    localparam int POS_W         = 32;
    localparam int HEADING_W     = 20;
    localparam int STEP_W        = 14;
    localparam int DIST_GAIN_W   = 32;
    localparam int TURN_GAIN_W   = 24;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int CORDIC_W      = 34;
    localparam int MUL_B_W       = CORDIC_W + 1;
    localparam int PROD_W        = SUM_W + MUL_B_W;

    localparam int STEP_LIMIT    = 4096;
    localparam logic [DIST_GAIN_W-1:0] DIST_GAIN_RESET = DIST_GAIN_W'(35387);
    localparam logic [TURN_GAIN_W-1:0] TURN_GAIN_RESET = TURN_GAIN_W'(1732900);
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = CORDIC_W'(32'h26DD3B6A);

    localparam logic [CFG_INDEX_W-1:0] CFG_DIST_GAIN = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_GAIN = CFG_INDEX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DU,
        ST_MUL_DT,
        ST_ROTATE,
        ST_MUL_SX,
        ST_MUL_SZ,
        ST_FINISH
    } ddo_state_t;

    typedef enum logic [1:0] {
        MUL_DIST,
        MUL_TURN,
        MUL_SIN,
        MUL_COS
    } mul_sel_t;

    typedef struct packed {
        logic              accept;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              cap_du;
        logic              cap_dt;
        logic              rotate;
        logic [ITER_W-1:0] iter;
        logic              cap_sx;
        logic              finish;
    } ddo_cmd_t;

    // Arctangent of 2^-i in 2^32 units per turn.
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] t;
        unique case (idx)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;
            5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;
            5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;
            5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/ddo_if.sv @@
// Request and result channel interfaces of the odometry block.
interface ddo_req_if import ddo_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [POS_W-1:0]   load_x;
    logic signed [POS_W-1:0]   load_z;
    logic [HEADING_W-1:0]      load_heading;

    modport source (
        output valid, func, left_speed, right_speed, load_x, load_z, load_heading,
        input  ready
    );
    modport sink (
        input  valid, func, left_speed, right_speed, load_x, load_z, load_heading,
        output ready
    );
endinterface

interface ddo_rsp_if import ddo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_z;
    logic [HEADING_W-1:0]     heading;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_z;

    modport source (
        output valid, pos_x, pos_z, heading, step_x, step_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_z, heading, step_x, step_z,
        output ready
    );
endinterface

@@ rtl/differential_drive_odometry.sv @@
// Top level of the dead-reckoning odometry block for a two-wheeled robot.
//
//   Channel | Direction | Handshake        | Payload
//   --------+-----------+------------------+---------------------------------------------
//   req     | in        | valid / ready    | func, left_speed, right_speed, load_x/z/heading
//   rsp     | out       | valid / ready    | pos_x, pos_z, heading, step_x, step_z
//   cfg     | in        | cfg_we only      | cfg_index, cfg_data
//
// A move request takes two steps on the shared multiplier, the shift-add CORDIC rotation,
// two more multiplier steps and one finish step, which registers the result; the next
// request is taken only after the finish step, so moves do not overlap.
// A load request goes straight to the finish step, which registers its result.
// Reset clears the pose to zero and restores the gain registers to their defaults.
// A stalled result holds the finished request in its last step; the pose is updated only
// when the result register is free, and a new request is taken while a result waits.
module differential_drive_odometry import ddo_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    ddo_req_if.sink                req,
    ddo_rsp_if.source              rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ddo_cmd_t cmd;

    // The sequencer walks each move request through the multiply, rotate and finish steps
    // and a load only through the finish step; it owns the handshake on both channels.
    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // The datapath holds the gains, the pose, the CORDIC registers and the multiplier.
    // The pose registers double as the result payload, since they change only when a
    // result is handed over.
    ddo_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (req.func),
        .left_speed   (req.left_speed),
        .right_speed  (req.right_speed),
        .load_x       (req.load_x),
        .load_z       (req.load_z),
        .load_heading (req.load_heading),
        .pos_x        (rsp.pos_x),
        .pos_z        (rsp.pos_z),
        .heading      (rsp.heading),
        .step_x       (rsp.step_x),
        .step_z       (rsp.step_z)
    );

endmodule

@@ rtl/ddo_ctrl.sv @@
// Sequencer of the odometry block: issues multiply, rotate and finish commands.
module ddo_ctrl import ddo_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_func,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output ddo_cmd_t cmd
);

    ddo_state_t        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_sel = MUL_DIST;
        cmd.iter    = iter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = in_func ? ST_FINISH : ST_MUL_DU;
                end
            end
            ST_MUL_DU:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIST;
                state_next  = ST_MUL_DT;
            end
            ST_MUL_DT:
            begin
                cmd.cap_du  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TURN;
                iter_next   = '0;
                state_next  = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
                cmd.cap_dt = (iter_reg == '0);
                if (iter_reg == ITER_W'(TRIG_ITERATIONS - 1))
                begin
                    state_next = ST_MUL_SX;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_MUL_SX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SIN;
                state_next  = ST_MUL_SZ;
            end
            ST_MUL_SZ:
            begin
                cmd.cap_sx  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_COS;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.finish || (out_valid_reg && !out_ready);
    end

endmodule

@@ rtl/ddo_datapath.sv @@
// Datapath of the odometry block: gains, shared multiplier, CORDIC and pose.
module ddo_datapath import ddo_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ddo_cmd_t                    cmd,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        func,
    input  logic signed [SPEED_W-1:0]   left_speed,
    input  logic signed [SPEED_W-1:0]   right_speed,
    input  logic signed [POS_W-1:0]     load_x,
    input  logic signed [POS_W-1:0]     load_z,
    input  logic [HEADING_W-1:0]        load_heading,
    output logic signed [POS_W-1:0]     pos_x,
    output logic signed [POS_W-1:0]     pos_z,
    output logic [HEADING_W-1:0]        heading,
    output logic signed [STEP_W-1:0]    step_x,
    output logic signed [STEP_W-1:0]    step_z
);

    // Clamps a rounded product to the step limit.
    function automatic logic signed [STEP_W-1:0] clamp_step(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [STEP_W-1:0] r;
        if (v > PROD_W'(STEP_LIMIT))
            r = STEP_W'(STEP_LIMIT);
        else if (v < -PROD_W'(STEP_LIMIT))
            r = -STEP_W'(STEP_LIMIT);
        else
            r = STEP_W'(v);
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0]  p,
        input logic signed [STEP_W-1:0] s
    );
        logic signed [POS_W:0]   t;
        logic signed [POS_W-1:0] r;
        t = (POS_W+1)'(p) + (POS_W+1)'(s);
        if (t[POS_W] != t[POS_W-1])
            r = t[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            r = t[POS_W-1:0];
        return r;
    endfunction

    logic [DIST_GAIN_W-1:0]     dist_gain_reg;
    logic [TURN_GAIN_W-1:0]     turn_gain_reg;
    logic signed [POS_W-1:0]    pose_x_reg, pose_x_next;
    logic signed [POS_W-1:0]    pose_z_reg, pose_z_next;
    logic [ANGLE_BITS-1:0]      pose_heading_reg, pose_heading_next;
    logic signed [STEP_W-1:0]   step_x_reg, step_z_reg;

    logic                       func_reg;
    logic signed [SUM_W-1:0]    sum_reg, diff_reg;
    logic signed [POS_W-1:0]    load_x_reg, load_z_reg;
    logic [HEADING_W-1:0]       load_heading_reg;
    logic signed [STEP_W-1:0]   du_reg, sx_reg;
    logic [ANGLE_BITS-1:0]      dt_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic                       flip_reg;

    logic signed [SUM_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_B_W-1:0]  x_ext, y_ext;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   du_round, dt_round, st_round;
    logic signed [STEP_W-1:0]   sz_now;
    logic [31:0]                ang32;
    logic                       flip_now;
    logic signed [CORDIC_W-1:0] xs, ys, atan_t;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_gain_reg <= DIST_GAIN_RESET;
            turn_gain_reg <= TURN_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIST_GAIN: dist_gain_reg <= cfg_data[DIST_GAIN_W-1:0];
                CFG_TURN_GAIN: turn_gain_reg <= cfg_data[TURN_GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Shared multiplier.
    assign x_ext = MUL_B_W'(x_reg);
    assign y_ext = MUL_B_W'(y_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DIST:
            begin
                mul_a = sum_reg;
                mul_b = $signed(MUL_B_W'(dist_gain_reg));
            end
            MUL_TURN:
            begin
                mul_a = diff_reg;
                mul_b = $signed(MUL_B_W'(turn_gain_reg));
            end
            MUL_SIN:
            begin
                mul_a = SUM_W'(du_reg);
                mul_b = flip_reg ? y_ext : -y_ext;
            end
            default:
            begin
                mul_a = SUM_W'(du_reg);
                mul_b = flip_reg ? x_ext : -x_ext;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign du_round  = (prod_reg + PROD_W'(65536)) >>> 17;
    assign dt_round  = prod_reg + PROD_W'(32768);
    assign st_round  = (prod_reg + PROD_W'(1 << 29)) >>> 30;
    assign sz_now    = clamp_step(st_round);

    // Heading scaled to a full 32-bit turn, folded into [-1/4, 1/4) turn.
    assign ang32    = 32'(pose_heading_reg) << (32 - ANGLE_BITS);
    assign flip_now = ang32[31] ^ ang32[30];

    assign xs     = x_reg >>> cmd.iter;
    assign ys     = y_reg >>> cmd.iter;
    assign atan_t = $signed(CORDIC_W'(atan_turn(ATAN_IDX_W'(cmd.iter))));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg         <= func;
            sum_reg          <= SUM_W'(left_speed) + SUM_W'(right_speed);
            diff_reg         <= SUM_W'(right_speed) - SUM_W'(left_speed);
            load_x_reg       <= load_x;
            load_z_reg       <= load_z;
            load_heading_reg <= load_heading;
            flip_reg         <= flip_now;
            x_reg            <= CORDIC_K;
            y_reg            <= '0;
            z_reg            <= CORDIC_W'($signed({ang32[31] ^ flip_now, ang32[30:0]}));
        end
        else if (cmd.rotate)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_t;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_t;
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.cap_du)
        begin
            du_reg <= clamp_step(du_round);
        end
        if (cmd.cap_dt)
        begin
            dt_reg <= dt_round[16 +: ANGLE_BITS];
        end
        if (cmd.cap_sx)
        begin
            sx_reg <= clamp_step(st_round);
        end
        if (cmd.finish)
        begin
            step_x_reg <= func_reg ? '0 : sx_reg;
            step_z_reg <= func_reg ? '0 : sz_now;
        end
    end

    // Pose update at the end of an item.
    always_comb
    begin
        if (func_reg)
        begin
            pose_x_next       = load_x_reg;
            pose_z_next       = load_z_reg;
            pose_heading_next = ANGLE_BITS'(load_heading_reg);
        end
        else
        begin
            pose_x_next       = sat_add(pose_x_reg, sx_reg);
            pose_z_next       = sat_add(pose_z_reg, sz_now);
            pose_heading_next = pose_heading_reg + dt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg       <= '0;
            pose_z_reg       <= '0;
            pose_heading_reg <= '0;
        end
        else if (cmd.finish)
        begin
            pose_x_reg       <= pose_x_next;
            pose_z_reg       <= pose_z_next;
            pose_heading_reg <= pose_heading_next;
        end
    end

    assign pos_x   = pose_x_reg;
    assign pos_z   = pose_z_reg;
    assign heading = HEADING_W'(pose_heading_reg);
    assign step_x  = step_x_reg;
    assign step_z  = step_z_reg;

endmodule

@@ test/differential_drive_odometry_tb.sv @@
// Self-checking testbench for the differential_drive_odometry pose integrator.
`timescale 1ns / 1ps

module differential_drive_odometry_tb import ddo_pkg::*;;

    // Request kinds carried on the func field.
    localparam logic FUNC_MOVE = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Configuration indexes that do not map to a register; writes to them are dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = CFG_INDEX_W'(3);

    localparam logic [DIST_GAIN_W-1:0] DIST_GAIN_DEFAULT = 32'd35387;
    localparam logic [TURN_GAIN_W-1:0] TURN_GAIN_DEFAULT = 24'd1732900;
    localparam logic [DIST_GAIN_W-1:0] DIST_GAIN_TOP     = '1;
    localparam logic [TURN_GAIN_W-1:0] TURN_GAIN_TOP     = '1;

    localparam logic signed [SPEED_W-1:0] SPEED_TOP    = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPEED_BOTTOM = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0]   POS_TOP      = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]   POS_BOTTOM   = {1'b1, {(POS_W-1){1'b0}}};

    localparam longint STEP_CAP     = 4096;
    localparam longint POS_HI       = (longint'(1) <<< 31) - 1;
    localparam longint POS_LO       = -(longint'(1) <<< 31);
    localparam longint DU_ROUND     = longint'(1) <<< 16;
    localparam longint DT_ROUND     = longint'(1) <<< 15;
    localparam longint TRIG_ROUND   = longint'(1) <<< 29;
    localparam longint CORDIC_START = 64'sh26DD3B6A;

    typedef struct packed {
        logic                      func;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [POS_W-1:0]   load_x;
        logic signed [POS_W-1:0]   load_z;
        logic [HEADING_W-1:0]      load_heading;
    } request_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_z;
        logic [HEADING_W-1:0]     heading;
        logic signed [STEP_W-1:0] step_x;
        logic signed [STEP_W-1:0] step_z;
    } pose_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ddo_req_if req_ch ();
    ddo_rsp_if rsp_ch ();

    differential_drive_odometry uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block: gains follow the configuration writes, the pose follows
    // every accepted request.
    logic [DIST_GAIN_W-1:0]  gain_dist;
    logic [TURN_GAIN_W-1:0]  gain_turn;
    logic signed [POS_W-1:0] est_x;
    logic signed [POS_W-1:0] est_z;
    logic [HEADING_W-1:0]    est_heading;

    request_t request_backlog[$];
    pose_t    awaited_poses[$];
    request_t req_shown;
    pose_t    pose_want;
    int       req_hold;
    int       rsp_hold;
    logic     no_idle;

    int failures        = 0;
    int results_checked = 0;
    int moves_queued    = 0;
    int loads_queued    = 0;
    int settings_used   = 1;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The run ends well before this watchdog, even with every gap at its longest.
    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Arctangent of 2^-i in 2^32 units per turn.
    function automatic longint arctan_turn32(input int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            default: return 0;
        endcase
    endfunction

    // Sine and cosine of a heading in Q30. Headings in the second and third quarter
    // are folded by half a turn first, and the results negated to match.
    function automatic void heading_sin_cos(input logic [HEADING_W-1:0] head,
                                            output longint sn, output longint cs);
        logic [31:0] ang;
        logic        flip;
        longint      x, y, z, xs, ys;
        ang  = 32'(head) << (32 - ANGLE_BITS);
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        if (flip)
            ang = ang - 32'h80000000;
        z = longint'($signed(ang));
        x = CORDIC_START;
        y = 0;
        for (int i = 0; i < TRIG_ITERATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_turn32(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_turn32(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    // Applies one request to the mirrored pose and returns the result the block owes.
    function automatic pose_t integrate_request(input request_t rq);
        longint l, r, du, dt, sn, cs, sx, sz;
        pose_t  p;
        sx = 0;
        sz = 0;
        if (rq.func == FUNC_LOAD)
        begin
            est_x       = rq.load_x;
            est_z       = rq.load_z;
            est_heading = rq.load_heading;
        end
        else
        begin
            l  = longint'($signed(rq.left_speed));
            r  = longint'($signed(rq.right_speed));
            du = ((l + r) * longint'(gain_dist) + DU_ROUND) >>> 17;
            dt = ((r - l) * longint'(gain_turn) + DT_ROUND) >>> 16;
            // A huge distance gain is tamed here, before it reaches the trig products.
            du = clip(du, -STEP_CAP, STEP_CAP);
            heading_sin_cos(est_heading, sn, cs);
            sx = clip((-(du * sn) + TRIG_ROUND) >>> 30, -STEP_CAP, STEP_CAP);
            sz = clip((-(du * cs) + TRIG_ROUND) >>> 30, -STEP_CAP, STEP_CAP);
            est_x = POS_W'(clip(longint'($signed(est_x)) + sx, POS_LO, POS_HI));
            est_z = POS_W'(clip(longint'($signed(est_z)) + sz, POS_LO, POS_HI));
            // The turn wraps in either direction by simply dropping the upper bits.
            est_heading = HEADING_W'(longint'(est_heading) + dt);
        end
        p.pos_x   = est_x;
        p.pos_z   = est_z;
        p.heading = est_heading;
        p.step_x  = STEP_W'(sx);
        p.step_z  = STEP_W'(sz);
        return p;
    endfunction

    function automatic void compare_field(input string field, input longint want,
                                          input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    function automatic logic signed [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 7))
            0:       return SPEED_TOP;
            1:       return SPEED_BOTTOM;
            2, 3:    return SPEED_W'(int'($urandom_range(0, 128)) - 64);
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    // Loaded positions lean toward the bounds so that later moves can saturate.
    function automatic logic signed [POS_W-1:0] pick_position();
        case ($urandom_range(0, 3))
            0:       return POS_TOP - POS_W'($urandom_range(0, 8191));
            1:       return POS_BOTTOM + POS_W'($urandom_range(0, 8191));
            default: return POS_W'($urandom);
        endcase
    endfunction

    // A move request; the load fields carry noise that the block must ignore.
    function automatic request_t move_req(input logic signed [SPEED_W-1:0] l,
                                          input logic signed [SPEED_W-1:0] r);
        request_t rq;
        rq.func         = FUNC_MOVE;
        rq.left_speed   = l;
        rq.right_speed  = r;
        rq.load_x       = POS_W'($urandom);
        rq.load_z       = POS_W'($urandom);
        rq.load_heading = HEADING_W'($urandom);
        return rq;
    endfunction

    // A load request; the wheel speeds carry noise that the block must ignore.
    function automatic request_t load_req(input logic signed [POS_W-1:0] x,
                                          input logic signed [POS_W-1:0] z,
                                          input logic [HEADING_W-1:0] h);
        request_t rq;
        rq.func         = FUNC_LOAD;
        rq.left_speed   = SPEED_W'($urandom);
        rq.right_speed  = SPEED_W'($urandom);
        rq.load_x       = x;
        rq.load_z       = z;
        rq.load_heading = h;
        return rq;
    endfunction

    task automatic queue_request(input request_t rq);
        request_backlog.push_back(rq);
        if (rq.func == FUNC_LOAD)
            loads_queued++;
        else
            moves_queued++;
    endtask

    // Mostly moves, a quarter of them straight ahead, with a load now and then.
    task automatic queue_random(input int count);
        logic signed [SPEED_W-1:0] l;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                queue_request(load_req(pick_position(), pick_position(),
                                       HEADING_W'($urandom)));
            else
            begin
                l = pick_speed();
                if ($urandom_range(0, 3) == 0)
                    queue_request(move_req(l, l));
                else
                    queue_request(move_req(l, pick_speed()));
            end
        end
    endtask

    // Returns once every queued request has gone in and its result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req_ch.valid || awaited_poses.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DIST_GAIN: gain_dist = data;
            CFG_TURN_GAIN: gain_turn = data[TURN_GAIN_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_gains(input logic [DIST_GAIN_W-1:0] dist_val,
                             input logic [TURN_GAIN_W-1:0] turn);
        write_reg(CFG_DIST_GAIN, dist_val);
        write_reg(CFG_TURN_GAIN, CFG_DATA_W'(turn));
        settings_used++;
    endtask

    // Request driver: one backlog item at a time, a random gap after each (none with
    // no_idle), and the expected pose worked out at the edge where the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.func         <= FUNC_MOVE;
            req_ch.left_speed   <= '0;
            req_ch.right_speed  <= '0;
            req_ch.load_x       <= '0;
            req_ch.load_z       <= '0;
            req_ch.load_heading <= '0;
            req_hold    = 0;
            est_x       = '0;
            est_z       = '0;
            est_heading = '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                awaited_poses.push_back(integrate_request(req_shown));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_hold > 0)
                begin
                    req_hold--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    req_shown = request_backlog.pop_front();
                    req_ch.func         <= req_shown.func;
                    req_ch.left_speed   <= req_shown.left_speed;
                    req_ch.right_speed  <= req_shown.right_speed;
                    req_ch.load_x       <= req_shown.load_x;
                    req_ch.load_z       <= req_shown.load_z;
                    req_ch.load_heading <= req_shown.load_heading;
                    req_ch.valid        <= 1'b1;
                    req_hold = no_idle ? 0 : $urandom_range(0, 10);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each taken result against the oldest expected pose and
    // then holds ready low for a random number of cycles, or not at all with no_idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_poses.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    failures++;
                end
                else
                begin
                    pose_want = awaited_poses.pop_front();
                    compare_field("pos_x", $signed(pose_want.pos_x), $signed(rsp_ch.pos_x));
                    compare_field("pos_z", $signed(pose_want.pos_z), $signed(rsp_ch.pos_z));
                    compare_field("heading", pose_want.heading, rsp_ch.heading);
                    compare_field("step_x", $signed(pose_want.step_x),
                                  $signed(rsp_ch.step_x));
                    compare_field("step_z", $signed(pose_want.step_z),
                                  $signed(rsp_ch.step_z));
                    results_checked++;
                end
                rsp_hold = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        cfg_we    = 1'b0;
        cfg_index = CFG_DIST_GAIN;
        cfg_data  = '0;
        no_idle   = 1'b0;
        gain_dist = DIST_GAIN_DEFAULT;
        gain_turn = TURN_GAIN_DEFAULT;
        // Let the clocked blocks reach their event controls before reset falls.
        #0 rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed requests at the reset gains: full speed both ways, spins that wrap
        // the heading in both directions, saturation of each position bound, headings
        // on the quarter-turn boundaries, and the smallest possible move.
        queue_request(move_req(0, 0));
        queue_request(move_req(SPEED_TOP, SPEED_TOP));
        queue_request(move_req(SPEED_BOTTOM, SPEED_BOTTOM));
        queue_request(move_req(SPEED_TOP, SPEED_BOTTOM));
        queue_request(move_req(SPEED_BOTTOM, SPEED_TOP));
        queue_request(load_req(POS_TOP, POS_BOTTOM, 20'hC0000));
        queue_request(move_req(SPEED_TOP, SPEED_TOP));
        queue_request(load_req(POS_BOTTOM, POS_BOTTOM, 20'h00000));
        queue_request(move_req(SPEED_TOP, SPEED_TOP));
        queue_request(load_req(POS_TOP, POS_TOP, 20'h80000));
        queue_request(move_req(SPEED_TOP, SPEED_TOP));
        queue_request(load_req(POS_BOTTOM, 0, 20'h40000));
        queue_request(move_req(SPEED_TOP, SPEED_TOP));
        queue_request(load_req(0, 0, 20'hFFFFF));
        queue_request(move_req(100, -100));
        queue_request(load_req(0, 0, 20'h3FFFF));
        queue_request(move_req(2000, 2000));
        queue_request(load_req(0, 0, 20'h7FFFF));
        queue_request(move_req(-2000, -2000));
        queue_request(load_req(0, 0, 20'hBFFFF));
        queue_request(move_req(1, 0));
        queue_request(move_req(-1, 0));
        queue_random(110);
        wait_drained();

        // Largest gains: the travel of a move is clamped unless its wheel sum is zero.
        // Writes to the spare indexes must not disturb either register.
        set_gains(DIST_GAIN_TOP, TURN_GAIN_TOP);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        queue_request(move_req(1, 1));
        queue_request(move_req(SPEED_TOP, SPEED_TOP));
        queue_request(move_req(SPEED_BOTTOM, SPEED_BOTTOM));
        queue_request(move_req(SPEED_TOP, SPEED_BOTTOM));
        queue_request(load_req(0, 0, 20'h20000));
        queue_request(move_req(SPEED_TOP, SPEED_TOP));
        queue_random(100);
        wait_drained();

        // Zero gains: moves must leave the pose unchanged.
        set_gains('0, '0);
        queue_request(move_req(SPEED_TOP, SPEED_TOP));
        queue_request(move_req(SPEED_BOTTOM, SPEED_TOP));
        queue_random(60);
        wait_drained();

        // Moderate random gains with both sides running flat out.
        no_idle = 1'b1;
        set_gains(DIST_GAIN_W'($urandom_range(0, 1 << 20)),
                  TURN_GAIN_W'($urandom_range(0, 1 << 22)));
        queue_random(110);
        wait_drained();
        no_idle = 1'b0;

        set_gains(DIST_GAIN_W'($urandom), TURN_GAIN_W'($urandom));
        queue_random(110);
        wait_drained();

        set_gains(DIST_GAIN_DEFAULT, TURN_GAIN_DEFAULT);
        queue_random(130);
        wait_drained();

        // Anything stray would show up during this wait.
        repeat (40) @(posedge clk);
        if (awaited_poses.size() != 0)
        begin
            $error("%0d results never arrived", awaited_poses.size());
            failures++;
        end

        $display("Covered %0d moves and %0d loads under %0d gain settings; %0d results checked.",
                 moves_queued, loads_queued, settings_used, results_checked);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ddo_pkg.sv
rtl/ddo_if.sv
rtl/ddo_ctrl.sv
rtl/ddo_datapath.sv
rtl/differential_drive_odometry.sv
test/differential_drive_odometry_tb.sv
